/* sv/lifo_stack_with_cursor_unit_macros.svh */
// ----------------------------------------------------------------------------
// LIFO stack with cursor: assertion macros
// Property wrappers for the top level, the one file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_CURSOR_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_CURSOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define LSCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LSCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/lscu_pkg.sv */
// ----------------------------------------------------------------------------
// LIFO stack with cursor: shared package
// Sizes, operation and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lscu_pkg;

    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int CNT_W     = 9;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_MPOP  = 3'd2,
        OP_PEEK  = 3'd3,
        OP_FWD   = 3'd4,
        OP_BWD   = 3'd5,
        OP_CLEAR = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One access to the entry store per request.
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

    // Everything the result needs apart from the word read from the store.
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] fill;
        logic             hit;
    } res_info_t;

endpackage

`default_nettype wire

/* sv/lscu_store.sv */
// ----------------------------------------------------------------------------
// LIFO stack with cursor: entry store
// Single-port word memory with a registered read; the read word holds until
// the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module lscu_store (
    input  wire logic                           clk,
    input  wire lscu_pkg::mem_req_t             req,
    output logic [lscu_pkg::WORD_BITS-1:0]      rdata
);
    import lscu_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/lscu_ctrl.sv */
// ----------------------------------------------------------------------------
// LIFO stack with cursor: control
// Holds the length and cursor, decodes each request into at most one store access
// and the status and fill level of its result.
// ----------------------------------------------------------------------------
`default_nettype none

module lscu_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fire,
    input  wire logic [lscu_pkg::OP_W-1:0]          opcode,
    input  wire logic [lscu_pkg::WORD_BITS-1:0]     push_value,
    input  wire logic [lscu_pkg::CNT_W-1:0]         drop_count,
    output lscu_pkg::mem_req_t                      mem_req,
    output lscu_pkg::res_info_t                     res
);
    import lscu_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cidx_reg, cidx_next;
    logic             cval_reg, cval_next;

    logic [LEN_W-1:0] len_dec;
    logic [LEN_W-1:0] fwd_idx;
    logic [LEN_W-1:0] mpop_len;
    logic             is_empty;
    logic             is_full;
    logic [ADDR_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    status_t          st;

    assign len_dec  = len_reg - 1'b1;
    assign is_empty = (len_reg == '0);
    assign is_full  = (len_reg == LEN_W'(DEPTH));
    assign fwd_idx  = cval_reg ? (cidx_reg + 1'b1) : '0;
    assign mpop_len = (len_reg < drop_count) ? '0 : (len_reg - drop_count);

    always_comb
    begin
        len_next  = len_reg;
        cidx_next = cidx_reg;
        cval_next = cval_reg;
        rd_addr   = '0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        st        = ST_OK;
        case (op_t'(opcode))
            OP_PUSH:
            begin
                if (is_full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    len_next = len_dec;
                    rd_en    = 1'b1;
                    rd_addr  = len_dec[ADDR_W-1:0];
                    if (len_dec == '0)
                    begin
                        cval_next = 1'b0;
                    end
                end
            end
            OP_MPOP:
            begin
                len_next = mpop_len;
                if (mpop_len == '0)
                begin
                    cval_next = 1'b0;
                end
            end
            OP_PEEK:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = len_dec[ADDR_W-1:0];
                end
            end
            OP_FWD:
            begin
                if (is_empty)
                begin
                    cval_next = 1'b0;
                    st        = ST_EMPTY;
                end
                else
                begin
                    cidx_next = fwd_idx;
                    if (fwd_idx >= len_reg)
                    begin
                        cval_next = 1'b0;
                        st        = ST_EMPTY;
                    end
                    else
                    begin
                        cval_next = 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = fwd_idx[ADDR_W-1:0];
                    end
                end
            end
            OP_BWD:
            begin
                if (is_empty)
                begin
                    cval_next = 1'b0;
                    st        = ST_EMPTY;
                end
                else if (!cval_reg || (cidx_reg >= len_reg))
                begin
                    cidx_next = len_dec;
                    cval_next = 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = len_dec[ADDR_W-1:0];
                end
                else if (cidx_reg == '0)
                begin
                    cval_next = 1'b0;
                    st        = ST_EMPTY;
                end
                else
                begin
                    cidx_next = cidx_reg - 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = cidx_next[ADDR_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                len_next = '0;
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            cidx_reg <= '0;
            cval_reg <= 1'b0;
        end
        else if (fire)
        begin
            len_reg  <= len_next;
            cidx_reg <= cidx_next;
            cval_reg <= cval_next;
        end
    end

    // A push writes at the old length; every read address lies below it.
    assign mem_req.we    = fire & wr_en;
    assign mem_req.re    = fire & rd_en;
    assign mem_req.addr  = wr_en ? len_reg[ADDR_W-1:0] : rd_addr;
    assign mem_req.wdata = push_value;

    assign res.status = st;
    assign res.fill   = len_next;
    assign res.hit    = rd_en;

endmodule

`default_nettype wire

/* sv/lifo_stack_with_cursor_unit.sv */
// ----------------------------------------------------------------------------
// LIFO stack with cursor: top level
// A 256-word stack with push, pop, multi-pop, peek, clear and a traversal
// cursor, one operation per request and one result per request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (in_valid / in_ready) with an opcode,
// a word to push and a drop count for multi-pop. Each request produces
// exactly one result on the output channel (out_valid / out_ready): the word
// read, a status code and the number of entries held afterwards.
// The result is registered: the outputs load at the clock edge that accepts
// the request. Throughput is one request per cycle while the receiver takes
// each result, as the single store port takes one write or one read per
// request while the length and cursor update at the same edge.
// The result sits in an output register. While the receiver stalls that
// register holds the result, in_ready is low and no further request is taken;
// in_ready returns in the cycle the result is taken, so a waiting request
// is accepted at that very edge.
// Reset empties the stack, clears the cursor and drops any pending result.
// Store contents are not cleared; only entries below the length are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lifo_stack_with_cursor_unit_macros.svh"

module lifo_stack_with_cursor_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [lscu_pkg::OP_W-1:0]          opcode,
    input  wire logic [lscu_pkg::WORD_BITS-1:0]     push_value,
    input  wire logic [lscu_pkg::CNT_W-1:0]         drop_count,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lscu_pkg::WORD_BITS-1:0]          read_value,
    output logic [lscu_pkg::ST_W-1:0]               status,
    output logic [lscu_pkg::LEN_W-1:0]              fill_level
);
    import lscu_pkg::*;

    logic                 fire;
    mem_req_t             mem_req;
    res_info_t            res;
    logic [WORD_BITS-1:0] rdata;

    logic                 out_valid_reg;
    logic [ST_W-1:0]      status_reg;
    logic [LEN_W-1:0]     fill_reg;
    logic                 hit_reg;

    // The output register frees up in the same cycle its result is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    lscu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .opcode     (opcode),
        .push_value (push_value),
        .drop_count (drop_count),
        .mem_req    (mem_req),
        .res        (res)
    );

    // The store's read register is loaded only on an accepted request, so it
    // stays put alongside the other result fields while the receiver stalls.
    lscu_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= res.status;
            fill_reg   <= res.fill;
            hit_reg    <= res.hit;
        end
    end

    // Requests that return no word report zero.
    assign out_valid  = out_valid_reg;
    assign read_value = hit_reg ? rdata : '0;
    assign status     = status_reg;
    assign fill_level = fill_reg;

    // Every accepted request leaves a result behind.
    `LSCU_ASSERT_NXT(a_fire_gives_result, clk, rst_n, fire, out_valid_reg, "result missing")

    // The stack can never report more entries than its depth.
    `LSCU_ASSERT_IMP(a_fill_bound, clk, rst_n, out_valid_reg, fill_reg <= LEN_W'(DEPTH), "fill level beyond depth")

    // A dropped push is only ever reported by a full stack.
    `LSCU_ASSERT_IMP(a_full_status, clk, rst_n, out_valid_reg && (status_reg == ST_FULL), fill_reg == LEN_W'(DEPTH), "full status without full stack")

    // A result with empty status returns no word and so reports zero.
    `LSCU_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid_reg && (status_reg == ST_EMPTY), read_value == '0, "word returned with empty status")

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIFO stack with cursor: self-checking testbench
// Drives push, pop, multi-pop, peek, clear and cursor steps through the
// request channel with random gaps and result stalls. Every result is checked
// field by field against a cycle-free model of the stack kept alongside.
// ----------------------------------------------------------------------------

module tb;

    import lscu_pkg::*;

    // The opcode that the block accepts but leaves without effect.
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    // ------------------------------------------------------------------------
    // Stack model and result store. Each accepted request is applied to the
    // model straight away and the outcome it should produce is queued; each
    // result taken from the block is compared with the oldest queued outcome.
    // ------------------------------------------------------------------------
    class stack_scoreboard;

        typedef struct packed {
            logic [WORD_BITS-1:0] word;
            status_t              st;
            logic [LEN_W-1:0]     fill;
        } outcome_t;

        logic [WORD_BITS-1:0] entries [DEPTH];
        int unsigned          held;
        int unsigned          cursor_pos;
        bit                   cursor_on;
        outcome_t             outcomes_due [$];
        int                   errors;
        int                   checked;
        int                   drops;
        int                   runoffs;
        int unsigned          peak;

        function void note_request(logic [OP_W-1:0] op, logic [WORD_BITS-1:0] word,
                                   logic [CNT_W-1:0] count);
            outcome_t o;
            o.word = '0;
            o.st   = ST_OK;
            case (op)
                OP_PUSH:
                    if (held >= DEPTH)
                    begin
                        o.st = ST_FULL;
                        drops++;
                    end
                    else
                    begin
                        entries[held] = word;
                        held++;
                    end
                OP_POP:
                    if (held == 0)
                        o.st = ST_EMPTY;
                    else
                    begin
                        held--;
                        o.word = entries[held];
                        if (held == 0)
                            cursor_on = 1'b0;
                    end
                OP_MPOP:
                begin
                    held = (held < count) ? 0 : held - count;
                    if (held == 0)
                        cursor_on = 1'b0;
                end
                OP_PEEK:
                    if (held == 0)
                        o.st = ST_EMPTY;
                    else
                        o.word = entries[held - 1];
                OP_FWD:
                    if (held == 0)
                    begin
                        cursor_on = 1'b0;
                        o.st      = ST_EMPTY;
                    end
                    else
                    begin
                        cursor_pos = cursor_on ? cursor_pos + 1 : 0;
                        if (cursor_pos >= held)
                        begin
                            cursor_on = 1'b0;
                            o.st      = ST_EMPTY;
                            runoffs++;
                        end
                        else
                        begin
                            cursor_on = 1'b1;
                            o.word    = entries[cursor_pos];
                        end
                    end
                OP_BWD:
                    if (held == 0)
                    begin
                        cursor_on = 1'b0;
                        o.st      = ST_EMPTY;
                    end
                    else if (!cursor_on || cursor_pos >= held)
                    begin
                        // No cursor, or one left above the top by pops: restart at the top.
                        cursor_pos = held - 1;
                        cursor_on  = 1'b1;
                        o.word     = entries[cursor_pos];
                    end
                    else if (cursor_pos == 0)
                    begin
                        cursor_on = 1'b0;
                        o.st      = ST_EMPTY;
                        runoffs++;
                    end
                    else
                    begin
                        cursor_pos--;
                        o.word = entries[cursor_pos];
                    end
                OP_CLEAR:
                    held = 0;
                default:
                    ;
            endcase
            if (held > peak)
                peak = held;
            o.fill = held[LEN_W-1:0];
            outcomes_due.push_back(o);
        endfunction

        function void check_result(logic [WORD_BITS-1:0] word, logic [ST_W-1:0] st,
                                   logic [LEN_W-1:0] fill);
            outcome_t o;
            if (outcomes_due.size() == 0)
            begin
                $error("result with no request outstanding: read_value %h status %0d",
                       word, st);
                errors++;
                return;
            end
            o = outcomes_due.pop_front();
            checked++;
            if (word !== o.word)
            begin
                $error("read_value: expected %h, got %h", o.word, word);
                errors++;
            end
            if (st !== o.st)
            begin
                $error("status: expected %0d, got %0d", o.st, st);
                errors++;
            end
            if (fill !== o.fill)
            begin
                $error("fill_level: expected %0d, got %0d", o.fill, fill);
                errors++;
            end
        endfunction

    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode;
    logic [WORD_BITS-1:0] push_value;
    logic [CNT_W-1:0]     drop_count;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_BITS-1:0] read_value;
    logic [ST_W-1:0]      status;
    logic [LEN_W-1:0]     fill_level;

    stack_scoreboard sb = new;
    int              requests_sent;
    // While set, neither side inserts gaps or stalls.
    bit              steady;

    lifo_stack_with_cursor_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .push_value (push_value),
        .drop_count (drop_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .fill_level (fill_level)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The receiver stalls at random, with a chance of 28 in a hundred, except during
    // the steady stretch, where it takes every result at once.
    always @(posedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 28);

    // Results are sampled at the clock edge that takes them. Outputs of the
    // block change only after the edge, so the values seen are those that
    // were presented during the cycle before it.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(read_value, status, fill_level);

    // Presents one request, with random idle cycles in front of it, and holds
    // it until the block takes it. The model is updated at the accepting edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_BITS-1:0] word,
                                input logic [CNT_W-1:0] count);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= word;
        drop_count <= count;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(op, word, count);
        requests_sent++;
    endtask

    // A request whose word and count the operation ignores: both carry noise.
    task automatic send_plain(input logic [OP_W-1:0] op);
        send_request(op, $urandom, CNT_W'($urandom_range(0, DEPTH)));
    endtask

    initial
    begin
        int unsigned      n;
        int               pick;
        int               wait_cycles;
        bit               filled;
        logic [CNT_W-1:0] cnt;

        filled      = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= '0;
        push_value <= '0;
        drop_count <= '0;
        steady     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Everything on an empty stack first, including a
        // multi-pop of zero, which still clears the cursor.
        send_plain(OP_POP);
        send_plain(OP_PEEK);
        send_plain(OP_FWD);
        send_plain(OP_BWD);
        send_request(OP_MPOP, 32'h0, 9'd0);
        // Extreme and alternating words.
        send_request(OP_PUSH, 32'h0000_0000, 9'd0);
        send_request(OP_PUSH, 32'hFFFF_FFFF, 9'h1FF);
        send_request(OP_PUSH, 32'hAAAA_AAAA, 9'h0AA);
        send_request(OP_PUSH, 32'h5555_5555, 9'h155);
        send_plain(OP_PEEK);
        // Forward walk from the bottom, running off the top.
        repeat (5) send_plain(OP_FWD);
        // Backward walk restarts at the top; a pop then leaves the cursor
        // above the top, so the next backward step restarts there again.
        send_plain(OP_BWD);
        send_plain(OP_POP);
        repeat (4) send_plain(OP_BWD);
        // Clear keeps the cursor, so the step after fresh pushes continues
        // from where it stood.
        send_plain(OP_FWD);
        send_plain(OP_CLEAR);
        send_request(OP_PUSH, 32'h1234_5678, 9'd0);
        send_request(OP_PUSH, 32'h8765_4321, 9'd0);
        send_plain(OP_FWD);
        send_plain(OP_SPARE);
        send_request(OP_MPOP, $urandom, 9'd0);
        send_request(OP_MPOP, $urandom, 9'd256);

        // Random part, built from short runs of a kind so that the cursor
        // walks and the stack fills and drains in ways a flat mix would miss.
        while (requests_sent < 750)
        begin
            steady <= (requests_sent >= 350 && requests_sent < 500);
            if (!filled && requests_sent >= 250)
            begin
                // Once per run: fill to the brim and push past it.
                filled = 1'b1;
                while (sb.held < DEPTH)
                    send_request(OP_PUSH, $urandom, CNT_W'($urandom_range(0, DEPTH)));
                repeat (3) send_request(OP_PUSH, $urandom, CNT_W'($urandom_range(0, DEPTH)));
                send_plain(OP_PEEK);
                repeat (3) send_plain(OP_BWD);
                send_plain(OP_POP);
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                n = $urandom_range(1, 12);
                repeat (n) send_request(OP_PUSH, $urandom, CNT_W'($urandom_range(0, DEPTH)));
            end
            else if (pick < 45)
            begin
                n = (sb.held + 2 > 40) ? 40 : sb.held + 2;
                repeat ($urandom_range(1, n)) send_plain(OP_FWD);
            end
            else if (pick < 60)
            begin
                n = (sb.held + 2 > 40) ? 40 : sb.held + 2;
                repeat ($urandom_range(1, n)) send_plain(OP_BWD);
            end
            else if (pick < 70)
            begin
                repeat ($urandom_range(1, 8)) send_plain(OP_POP);
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 4))
                    0:       cnt = '0;
                    1:       cnt = CNT_W'($urandom_range(1, (sb.held > 0) ? sb.held : 1));
                    2:       cnt = CNT_W'(sb.held);
                    3:       cnt = CNT_W'($urandom_range(0, DEPTH));
                    default: cnt = CNT_W'(DEPTH);
                endcase
                send_request(OP_MPOP, $urandom, cnt);
            end
            else if (pick < 85)
                send_plain(OP_PEEK);
            else if (pick < 88)
                send_plain(OP_CLEAR);
            else
            begin
                // Noise: any opcode, the spare one included, with random fields.
                repeat ($urandom_range(1, 6))
                    send_request(OP_W'($urandom_range(0, 7)), $urandom,
                                 CNT_W'($urandom_range(0, DEPTH)));
            end
        end

        in_valid <= 1'b0;
        steady   <= 1'b0;
        wait_cycles = 0;
        while (sb.outcomes_due.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        // Then wait on to catch any stray result.
        repeat (4) @(posedge clk);
        if (sb.outcomes_due.size() != 0)
        begin
            $error("%0d results never arrived", sb.outcomes_due.size());
            sb.errors++;
        end

        $display("Covered %0d requests with %0d results checked; the stack peaked at %0d of %0d.",
                 requests_sent, sb.checked, sb.peak, DEPTH);
        $display("Pushes dropped on a full stack: %0d; cursor steps off an end: %0d.",
                 sb.drops, sb.runoffs);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Safety net: a run that hangs is a failure.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/lscu_pkg.sv
sv/lscu_store.sv
sv/lscu_ctrl.sv
sv/lifo_stack_with_cursor_unit.sv
verif/tb.sv
